// File: sv/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants for the 8-bit accumulator CPU
// Holds command and opcode encodings, the sequencer state type and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int unsigned MEM_BYTES = 256;
  localparam int unsigned AW        = $clog2(MEM_BYTES);

  // Item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // Operations, opcode bits 7:4 (8 and up halt)
  localparam logic [3:0] OP_MOV = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_BRA = 4'd3;
  localparam logic [3:0] OP_CMP = 4'd4;
  localparam logic [3:0] OP_BEQ = 4'd5;
  localparam logic [3:0] OP_BNE = 4'd6;
  localparam logic [3:0] OP_EXG = 4'd7;

  // Addressing modes, opcode bits 1:0
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_IMM    = 2'd1;
  localparam logic [1:0] MODE_INDEX  = 2'd2;
  localparam logic [1:0] MODE_PCREL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_FETCH_IR,
    S_FETCH_OPND,
    S_DECODE,
    S_EXEC,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_RD_ADDR,
    MEM_WR_ADDR,
    MEM_RD_PC,
    MEM_RD_PC1,
    MEM_RD_EA,
    MEM_WR_EA
  } mem_op_e;

  typedef struct packed {
    logic    in_load;
    mem_op_e mem_op;
    logic    ir_load;
    logic    decode;
    logic    exec;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic stopped;
  } stat_t;

endpackage

// File: sv/acpu_if.sv
// ----------------------------------------------------------------------------
// acpu_if: valid/ready channels of the accumulator CPU
// acpu_in_if carries item commands, acpu_out_if carries register snapshots.
// ----------------------------------------------------------------------------
interface acpu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] addr;
  logic [7:0] wdata;

  modport source (output valid, output cmd, output addr, output wdata, input ready);
  modport sink   (input valid, input cmd, input addr, input wdata, output ready);
endinterface

interface acpu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [7:0] pc_value;
  logic [7:0] d0_value;
  logic [7:0] a0_value;
  logic       zero_flag;
  logic       halted;

  modport source (output valid, output rdata, output pc_value, output d0_value,
                  output a0_value, output zero_flag, output halted, input ready);
  modport sink   (input valid, input rdata, input pc_value, input d0_value,
                  input a0_value, input zero_flag, input halted, output ready);
endinterface

// File: sv/acpu_ctrl.sv
// ----------------------------------------------------------------------------
// acpu_ctrl: sequencer of the accumulator CPU
// Steps each item through memory access, fetch, decode and execute, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module acpu_ctrl import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_WRITE) begin
            state_d = S_WRITE;
          end else if (in_cmd_i == CMD_READ) begin
            state_d = S_READ;
          end else if (in_cmd_i == CMD_EXEC && !stat_i.stopped) begin
            state_d = S_FETCH_IR;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WRITE:      state_d = S_DONE;
      S_READ:       state_d = S_DONE;
      S_FETCH_IR:   state_d = S_FETCH_OPND;
      S_FETCH_OPND: state_d = S_DECODE;
      S_DECODE:     state_d = S_EXEC;
      S_EXEC:       state_d = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.mem_op = MEM_IDLE;
    in_ready_o    = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.in_load = in_valid_i;
      end
      S_WRITE:      ctrl_o.mem_op = MEM_WR_ADDR;
      S_READ:       ctrl_o.mem_op = MEM_RD_ADDR;
      S_FETCH_IR:   ctrl_o.mem_op = MEM_RD_PC;
      S_FETCH_OPND: begin
        ctrl_o.mem_op  = MEM_RD_PC1;
        ctrl_o.ir_load = 1'b1;
      end
      S_DECODE: begin
        ctrl_o.mem_op = MEM_RD_EA;
        ctrl_o.decode = 1'b1;
      end
      S_EXEC: begin
        ctrl_o.mem_op = MEM_WR_EA;
        ctrl_o.exec   = 1'b1;
      end
      S_DONE: begin
        if (slot_free) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/acpu_dpath.sv
// ----------------------------------------------------------------------------
// acpu_dpath: datapath of the accumulator CPU
// Single-port 256-byte memory with registered read, the CPU registers,
// instruction decode and execute, and the result register.
// ----------------------------------------------------------------------------
module acpu_dpath import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  output stat_t      stat_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o,
  output logic [7:0] pc_value_o,
  output logic [7:0] d0_value_o,
  output logic [7:0] a0_value_o,
  output logic       zero_flag_o,
  output logic       halted_o
);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;

  logic [1:0] cmd_q;
  logic [7:0] addr_q, wdata_q;
  logic [7:0] ir_q, opnd_q, opnd_d, ea_q, ea_d;
  logic [7:0] pc_q, pc_d, d0_q, d0_d, a0_q, a0_d;
  logic       z_q, z_d, stop_q, stop_d;

  logic [7:0] rdata_q, pcv_q, d0v_q, a0v_q;
  logic       zv_q, hv_q;

  logic [3:0] op;
  logic       dir;
  logic [1:0] mode;
  logic [7:0] pc_next, src, res, target;
  logic       exec_we;
  logic [7:0] exec_wv;

  logic       mem_we, mem_re;
  logic [7:0] mem_addr, mem_wv;

  assign op   = ir_q[7:4];
  assign dir  = ir_q[2];
  assign mode = ir_q[1:0];

  // decode: mem_q holds the operand byte here
  assign pc_next = pc_q + 8'd2;
  assign opnd_d  = mem_q;
  always_comb begin
    unique case (mode)
      MODE_INDEX: ea_d = a0_q + mem_q;
      MODE_PCREL: ea_d = pc_next + mem_q;
      default:    ea_d = mem_q;
    endcase
  end

  // execute: mem_q holds the byte at ea_q here
  assign src    = (mode == MODE_IMM) ? opnd_q : mem_q;
  assign target = (mode == MODE_IMM) ? opnd_q : pc_q + opnd_q;

  always_comb begin
    pc_d    = pc_q;
    d0_d    = d0_q;
    a0_d    = a0_q;
    z_d     = z_q;
    stop_d  = stop_q;
    exec_we = 1'b0;
    exec_wv = d0_q;
    res     = '0;
    if (ctrl_i.decode) begin
      pc_d = pc_next;
    end else if (ctrl_i.exec) begin
      unique case (op)
        OP_MOV: begin
          if (dir) begin
            d0_d = src;
          end else if (mode != MODE_IMM) begin
            exec_we = 1'b1;
          end
        end
        OP_ADD, OP_SUB: begin
          if (dir) begin
            res  = (op == OP_ADD) ? d0_q + src : d0_q - src;
            d0_d = res;
            if (res == '0) z_d = 1'b1;
          end else if (mode != MODE_IMM) begin
            res     = (op == OP_ADD) ? mem_q + d0_q : d0_q - mem_q;
            exec_we = 1'b1;
            exec_wv = res;
            if (res == '0) z_d = 1'b1;
          end
        end
        OP_BRA: pc_d = target;
        OP_CMP: begin
          if (dir) begin
            res = d0_q - src;
            z_d = (res == '0);
          end
        end
        OP_BEQ: if (z_q)  pc_d = target;
        OP_BNE: if (!z_q) pc_d = target;
        OP_EXG: begin
          d0_d = a0_q;
          a0_d = d0_q;
        end
        default: stop_d = 1'b1;
      endcase
    end
  end

  // memory port select
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = addr_q;
    mem_wv   = wdata_q;
    unique case (ctrl_i.mem_op)
      MEM_IDLE:    ;
      MEM_RD_ADDR: mem_re = 1'b1;
      MEM_WR_ADDR: mem_we = 1'b1;
      MEM_RD_PC: begin
        mem_re   = 1'b1;
        mem_addr = pc_q;
      end
      MEM_RD_PC1: begin
        mem_re   = 1'b1;
        mem_addr = pc_q + 8'd1;
      end
      MEM_RD_EA: begin
        mem_re   = 1'b1;
        mem_addr = ea_d;
      end
      MEM_WR_EA: begin
        mem_we   = exec_we;
        mem_addr = ea_q;
        mem_wv   = exec_wv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr[AW-1:0]] <= mem_wv;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr[AW-1:0]];
    end
  end

  // item, instruction and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_load) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
    end
    if (ctrl_i.ir_load) begin
      ir_q <= mem_q;
    end
    if (ctrl_i.decode) begin
      opnd_q <= opnd_d;
      ea_q   <= ea_d;
    end
    if (ctrl_i.out_load) begin
      rdata_q <= (cmd_q == CMD_READ) ? mem_q : 8'd0;
      pcv_q   <= pc_q;
      d0v_q   <= d0_q;
      a0v_q   <= a0_q;
      zv_q    <= z_q;
      hv_q    <= stop_q;
    end
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      d0_q   <= '0;
      a0_q   <= '0;
      z_q    <= 1'b0;
      stop_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      d0_q   <= d0_d;
      a0_q   <= a0_d;
      z_q    <= z_d;
      stop_q <= stop_d;
    end
  end

  assign stat_o.stopped = stop_q;
  assign rdata_o        = rdata_q;
  assign pc_value_o     = pcv_q;
  assign d0_value_o     = d0v_q;
  assign a0_value_o     = a0v_q;
  assign zero_flag_o    = zv_q;
  assign halted_o       = hv_q;

endmodule

// File: sv/accumulator_cpu_8bit_step_core.sv
// Path: write and read pass their access state, execute passes fetch, decode
// and execute, halted or unused commands go to done; the output register adds
// no stall while it drains. Throughput: one item at a time; the next is taken
// in the cycle after the result loads, the single memory port serving opcode,
// operand and data in turn. Reset: asynchronous active low; pc, d0, a0, flags
// and valids clear; memory keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_step_core: tiny 8-bit accumulator CPU with 256 bytes
// Each input transfer writes a memory byte, reads one, or steps one
// instruction; each produces one output transfer with the register state.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_step_core import acpu_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  acpu_in_if.sink     in_i,
  acpu_out_if.source  out_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer: takes a transfer only when idle, walks the memory port
  // through its accesses and loads the result once the output slot is free.
  acpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Datapath: memory, registers, decode/execute and the result register.
  acpu_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (in_i.cmd),
    .addr_i      (in_i.addr),
    .wdata_i     (in_i.wdata),
    .rdata_o     (out_o.rdata),
    .pc_value_o  (out_o.pc_value),
    .d0_value_o  (out_o.d0_value),
    .a0_value_o  (out_o.a0_value),
    .zero_flag_o (out_o.zero_flag),
    .halted_o    (out_o.halted)
  );

endmodule

// File: tb/acpu_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_tb_pkg: shadow CPU and result scoreboard for the accumulator CPU bench
// Mirrors memory and registers per accepted transfer and checks each output
// snapshot against the oldest predicted one.
// ----------------------------------------------------------------------------
package acpu_tb_pkg;
  import acpu_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [3:0] OP_STP    = 4'd15;
  localparam logic       DIR_LOAD  = 1'b1;
  localparam logic       DIR_STORE = 1'b0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] addr;
    logic [7:0] wdata;
  } cpu_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] pc;
    logic [7:0] d0;
    logic [7:0] a0;
    logic       zf;
    logic       halted;
  } cpu_snap_t;

  class acpu_scoreboard;
    bit [7:0]    mem [MEM_BYTES];
    bit          written [MEM_BYTES];
    bit [7:0]    pc, d0, a0;
    bit          zf, stopped;
    cpu_snap_t   expected_snaps[$];
    int unsigned n_items, n_errors;

    function bit [7:0] data_addr(bit [1:0] mode, bit [7:0] opnd, bit [7:0] pc_next);
      case (mode)
        MODE_INDEX: return a0 + opnd;
        MODE_PCREL: return pc_next + opnd;
        default:    return opnd;
      endcase
    endfunction

    // True when the instruction fetches a data byte besides its two code bytes.
    function bit reads_data(bit [7:0] ir);
      bit [3:0] op;
      op = ir[7:4];
      if (ir[1:0] == MODE_IMM) return 1'b0;
      return (op == OP_ADD) || (op == OP_SUB) ||
             (ir[2] && ((op == OP_MOV) || (op == OP_CMP)));
    endfunction

    function void store(bit [7:0] a, bit [7:0] v);
      mem[a]     = v;
      written[a] = 1'b1;
    endfunction

    function bit [7:0] operand_value(bit [1:0] mode, bit [7:0] opnd);
      if (mode == MODE_IMM) return opnd;
      return mem[data_addr(mode, opnd, pc)];
    endfunction

    function void jump(bit [1:0] mode, bit [7:0] opnd);
      if (mode == MODE_IMM) pc = opnd;
      else pc = pc + opnd;
    endfunction

    function void run_instr();
      bit [7:0] ir, opnd, ea, v, pc1;
      bit [1:0] mode;
      bit       dir;
      bit [3:0] op;
      pc1  = pc + 8'd1;
      ir   = mem[pc];
      opnd = mem[pc1];
      mode = ir[1:0];
      dir  = ir[2];
      op   = ir[7:4];
      pc   = pc + 8'd2;
      case (op)
        OP_MOV: begin
          if (dir) d0 = operand_value(mode, opnd);
          else if (mode != MODE_IMM) store(data_addr(mode, opnd, pc), d0);
        end
        OP_ADD, OP_SUB: begin
          if (dir) begin
            v  = operand_value(mode, opnd);
            d0 = (op == OP_ADD) ? d0 + v : d0 - v;
            if (d0 == 8'd0) zf = 1'b1;
          end else if (mode != MODE_IMM) begin
            ea = data_addr(mode, opnd, pc);
            v  = mem[ea];
            v  = (op == OP_ADD) ? v + d0 : d0 - v;
            store(ea, v);
            if (v == 8'd0) zf = 1'b1;
          end
        end
        OP_BRA: jump(mode, opnd);
        OP_CMP: begin
          if (dir) begin
            v  = d0 - operand_value(mode, opnd);
            zf = (v == 8'd0);
          end
        end
        OP_BEQ: if (zf) jump(mode, opnd);
        OP_BNE: if (!zf) jump(mode, opnd);
        OP_EXG: begin
          v  = d0;
          d0 = a0;
          a0 = v;
        end
        default: stopped = 1'b1;
      endcase
    endfunction

    function void note_item(cpu_req_t req);
      cpu_snap_t s;
      s.rdata = 8'd0;
      case (req.cmd)
        CMD_WRITE: store(req.addr, req.wdata);
        CMD_READ:  s.rdata = mem[req.addr];
        CMD_EXEC:  if (!stopped) run_instr();
        default:   ;
      endcase
      if (req.cmd != CMD_NONE) n_items++;
      s.pc     = pc;
      s.d0     = d0;
      s.a0     = a0;
      s.zf     = zf;
      s.halted = stopped;
      expected_snaps.push_back(s);
    endfunction

    function void field_check(string tag, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_errors++;
        if (n_errors <= 40)
          $display("%0t: %s mismatch, expected %02h, actual %02h", $time, tag, want, got);
      end
    endfunction

    function void check_snapshot(cpu_snap_t got);
      cpu_snap_t want;
      if (expected_snaps.size() == 0) begin
        n_errors++;
        if (n_errors <= 40)
          $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        return;
      end
      want = expected_snaps.pop_front();
      field_check("rdata", want.rdata, got.rdata);
      field_check("pc_value", want.pc, got.pc);
      field_check("d0_value", want.d0, got.d0);
      field_check("a0_value", want.a0, got.a0);
      field_check("zero_flag", {7'd0, want.zf}, {7'd0, got.zf});
      field_check("halted", {7'd0, want.halted}, {7'd0, got.halted});
    endfunction
  endclass

endpackage

// File: tb/tb_accumulator_cpu_8bit_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_cpu_8bit_step_core: self-checking bench of the 8-bit CPU core
// Runs a short hand-built program through every operation, then random
// memory traffic and single steps that never touch unwritten memory, under
// bursty input and stalling output, and ends on a halting instruction.
// ----------------------------------------------------------------------------
module tb_accumulator_cpu_8bit_step_core;
  import acpu_pkg::*;
  import acpu_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PAUSE_AT     = 800;

  logic clk_i;
  logic rst_ni;

  acpu_in_if  in_if ();
  acpu_out_if out_if ();

  accumulator_cpu_8bit_step_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  acpu_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  cpu_snap_t   seen;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset low from the start, release on a falling edge
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Cycle budget: drop the run if the core stops answering
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sample each output transfer at the rising edge and hand it to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.rdata  = out_if.rdata;
      seen.pc     = out_if.pc_value;
      seen.d0     = out_if.d0_value;
      seen.a0     = out_if.a0_value;
      seen.zf     = out_if.zero_flag;
      seen.halted = out_if.halted;
      sb.check_snapshot(seen);
    end
  end

  // Receiver: cycle through four stall patterns in turn by the cycle count, and
  // once hold off for a long stretch so the core backs up into its input.
  initial begin : rx_stalls
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.n_items >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case ((cycle_count / 97) % 4)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 1) == 0);
          2:       out_if.ready <= ($urandom_range(0, 7) != 0);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one transfer and wait for it to be taken. The sender runs in bursts:
  // when a burst is used up, drop valid for a random gap and start a new one.
  task automatic send(logic [1:0] cmd, logic [7:0] addr, logic [7:0] wdata);
    cpu_req_t req;
    req = '{cmd, addr, wdata};
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      // an occasional long burst leaves a stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end else begin
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.addr  <= addr;
    in_if.wdata <= wdata;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    burst_left--;
    sb.note_item(req);
  endtask

  // Stop offering and wait until every predicted snapshot has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_snaps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] encode(logic [3:0] op, logic dir, logic [1:0] mode,
                                        logic spare);
    return {op, spare, dir, mode};
  endfunction

  // Any non-halting opcode; bit 3, direction and mode left random
  function automatic logic [7:0] pick_opcode();
    logic [7:0] r;
    r      = 8'($urandom);
    r[7:4] = 4'($urandom_range(0, 7));
    return r;
  endfunction

  // Bias immediates toward d0 and -d0 so zero results come up often
  function automatic logic [7:0] pick_operand(logic [7:0] ir);
    if (ir[1:0] == MODE_IMM) begin
      case ($urandom_range(0, 3))
        0:       return sb.d0;
        1:       return -sb.d0;
        default: return 8'($urandom);
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic put_instr(logic [7:0] at, logic [7:0] ir, logic [7:0] opnd);
    logic [7:0] at1;
    at1 = at + 8'd1;
    send(CMD_WRITE, at, ir);
    send(CMD_WRITE, at1, opnd);
  endtask

  // Step one instruction. With fresh set, load a new random instruction at pc
  // first; otherwise run what is there, patching only unwritten or halting
  // bytes. Write the data byte too if the step would read it unwritten.
  task automatic step_cpu(bit fresh);
    logic [7:0] pc1, ir, ea;
    if (!sb.stopped) begin
      pc1 = sb.pc + 8'd1;
      if (fresh || !sb.written[sb.pc] || sb.mem[sb.pc][7])
        send(CMD_WRITE, sb.pc, pick_opcode());
      if (fresh || !sb.written[pc1])
        send(CMD_WRITE, pc1, pick_operand(sb.mem[sb.pc]));
      ir = sb.mem[sb.pc];
      if (sb.reads_data(ir)) begin
        ea = sb.data_addr(ir[1:0], sb.mem[pc1], sb.pc + 8'd2);
        if (!sb.written[ea]) send(CMD_WRITE, ea, 8'($urandom));
      end
    end
    send(CMD_EXEC, 8'($urandom), 8'($urandom));
  endtask

  // Read a byte known to be written; fall back to writing one
  task automatic read_back();
    logic [7:0]  a;
    int unsigned tries;
    a     = 8'($urandom);
    tries = 0;
    while (!sb.written[a] && tries < 8) begin
      a = 8'($urandom);
      tries++;
    end
    if (sb.written[a]) send(CMD_READ, a, 8'($urandom));
    else send(CMD_WRITE, a, 8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned target;
    int unsigned pick;
    bit          paused;
    logic [3:0]  stop_op;
    paused      = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_WRITE;
    in_if.addr  = 8'd0;
    in_if.wdata = 8'd0;
    wait (rst_ni === 1'b1);

    // Directed program: every operation, index and pc-relative wrap, zero flag
    // set by SUB and cleared by CMP, taken BEQ/BNE, store via pc-relative.
    put_instr(8'h00, encode(OP_MOV, DIR_LOAD, MODE_IMM, 1'b0), 8'h80);    // d0 = 80
    put_instr(8'h02, encode(OP_EXG, DIR_STORE, MODE_DIRECT, 1'b0), 8'h00); // a0 = 80
    put_instr(8'h04, encode(OP_ADD, DIR_LOAD, MODE_INDEX, 1'b0), 8'h80);  // a0+80 wraps to 0
    put_instr(8'h06, encode(OP_SUB, DIR_LOAD, MODE_IMM, 1'b0), 8'h05);    // d0 = 0, z set
    put_instr(8'h08, encode(OP_BEQ, DIR_STORE, MODE_PCREL, 1'b0), 8'hF0); // pc -> FA
    put_instr(8'hFA, encode(OP_CMP, DIR_LOAD, MODE_IMM, 1'b0), 8'hFF);    // z cleared
    put_instr(8'hFC, encode(OP_MOV, DIR_STORE, MODE_PCREL, 1'b1), 8'h03); // ea wraps to 01
    put_instr(8'hFE, encode(OP_BNE, DIR_STORE, MODE_DIRECT, 1'b0), 8'h10); // pc wraps, -> 10
    put_instr(8'h10, encode(OP_BRA, DIR_LOAD, MODE_IMM, 1'b0), 8'h40);    // pc -> 40
    repeat (9) send(CMD_EXEC, 8'hFF, 8'h00);
    send(CMD_READ, 8'h01, 8'hFF);

    // Random traffic: mostly well-formed load-and-step sequences, plus plain
    // writes, reads of written bytes and the unused command.
    target = sb.n_items + RANDOM_ITEMS;
    while (sb.n_items < target) begin
      if (!paused && sb.n_items >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) step_cpu(1'b1);
      else if (pick < 72) step_cpu(1'b0);
      else if (pick < 86) send(CMD_WRITE, 8'($urandom), 8'($urandom));
      else if (pick < 96) read_back();
      else send(CMD_NONE, 8'($urandom), 8'($urandom));
    end

    // Halt last: any code from 8 up stops the core for good; then check that
    // steps are ignored while memory access still works.
    stop_op = ($urandom_range(0, 1) == 0) ? OP_STP : 4'($urandom_range(8, 14));
    put_instr(sb.pc, encode(stop_op, 1'($urandom), 2'($urandom), 1'($urandom)),
              8'($urandom));
    send(CMD_EXEC, 8'($urandom), 8'($urandom));
    send(CMD_EXEC, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, 8'h00, 8'hA5);
    send(CMD_READ, 8'h00, 8'h5A);
    send(CMD_NONE, 8'hFF, 8'hFF);
    send(CMD_EXEC, 8'h00, 8'h00);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.expected_snaps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
sv/acpu_pkg.sv
sv/acpu_if.sv
sv/acpu_ctrl.sv
sv/acpu_dpath.sv
sv/accumulator_cpu_8bit_step_core.sv
tb/acpu_tb_pkg.sv
tb/tb_accumulator_cpu_8bit_step_core.sv
